[src/nlc_pkg.sv]
// ---------------------------------------------------------------------------
// nlc_pkg: shared definitions for the numeric literal classifier
// Phase and verdict codes, character constants and the per-token state type.
// ---------------------------------------------------------------------------
`default_nettype none

package nlc_pkg;

  // Token phases
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_MINUS = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Verdict codes
  localparam logic [1:0] V_NONE  = 2'd0;
  localparam logic [1:0] V_INT   = 2'd1;
  localparam logic [1:0] V_FLOAT = 2'd2;
  localparam logic [1:0] V_ERR   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Reset value of the exponent mode register
  localparam logic ALLOW_EXP_RESET = 1'b1;

  // State carried from one character of a token to the next
  typedef struct packed {
    logic [1:0] phase;
    logic       seen_point;
    logic       seen_hex_marker;
    logic       seen_exponent;
    logic       prev_was_point;
    logic [1:0] early_verdict;
  } tok_state_t;

  localparam tok_state_t TOK_CLEAR = '{
    phase:           PH_LEAD,
    seen_point:      1'b0,
    seen_hex_marker: 1'b0,
    seen_exponent:   1'b0,
    prev_was_point:  1'b0,
    early_verdict:   V_NONE
  };

  // Result of classifying one character
  typedef struct packed {
    tok_state_t state_next;
    logic [1:0] verdict;
  } step_res_t;

endpackage

`default_nettype wire

[src/nlc_in_if.sv]
// ---------------------------------------------------------------------------
// nlc_in_if: character input channel
// Carries one token character and its final-character flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface nlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

[src/nlc_out_if.sv]
// ---------------------------------------------------------------------------
// nlc_out_if: verdict output channel
// Carries one verdict per completed token.
// ---------------------------------------------------------------------------
`default_nettype none

interface nlc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

[src/nlc_cfg_if.sv]
// ---------------------------------------------------------------------------
// nlc_cfg_if: configuration write channel
// Carries the write data of the exponent mode register.
// ---------------------------------------------------------------------------
`default_nettype none

interface nlc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/nlc_step.sv]
// ---------------------------------------------------------------------------
// nlc_step: one-character classification step
// Computes the next token state and, for a final character, the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module nlc_step (
  input  wire logic [7:0]          ch,
  input  wire logic                last,
  input  wire logic                allow_exponent,
  input  wire nlc_pkg::tok_state_t state_cur,
  output nlc_pkg::step_res_t       res
);

  nlc_pkg::tok_state_t upd;
  logic is_digit;
  logic is_space;
  logic is_hex_letter;

  // Decode the character classes
  assign is_digit      = (ch >= nlc_pkg::CH_ZERO) && (ch <= nlc_pkg::CH_NINE);
  assign is_space      = (ch == nlc_pkg::CH_SPACE) ||
                         ((ch >= nlc_pkg::CH_TAB) && (ch <= nlc_pkg::CH_CR));
  assign is_hex_letter = (ch >= nlc_pkg::CH_A) && (ch <= nlc_pkg::CH_F);

  // Advance the token state for this character
  always_comb begin
    upd = state_cur;
    unique case (state_cur.phase)
      nlc_pkg::PH_LEAD: begin
        if (is_space) begin
          upd.phase = nlc_pkg::PH_LEAD;
        end else if (ch == nlc_pkg::CH_MINUS) begin
          upd.phase = nlc_pkg::PH_MINUS;
        end else if (is_digit) begin
          upd.phase = nlc_pkg::PH_BODY;
        end else begin
          upd.phase         = nlc_pkg::PH_DONE;
          upd.early_verdict = nlc_pkg::V_NONE;
        end
      end
      nlc_pkg::PH_MINUS: begin
        if (is_digit) begin
          upd.phase = nlc_pkg::PH_BODY;
        end else begin
          upd.phase         = nlc_pkg::PH_DONE;
          upd.early_verdict = nlc_pkg::V_NONE;
        end
      end
      nlc_pkg::PH_BODY: begin
        upd.prev_was_point = 1'b0;
        priority if (is_digit) begin
          upd.phase = nlc_pkg::PH_BODY;
        end else if (state_cur.seen_hex_marker && is_hex_letter) begin
          upd.phase = nlc_pkg::PH_BODY;
        end else if (allow_exponent && (ch == nlc_pkg::CH_E)) begin
          if (state_cur.seen_exponent) begin
            upd.phase         = nlc_pkg::PH_DONE;
            upd.early_verdict = nlc_pkg::V_ERR;
          end else begin
            upd.seen_exponent = 1'b1;
            upd.seen_point    = 1'b1;
          end
        end else if (!state_cur.seen_hex_marker && (ch == nlc_pkg::CH_X)) begin
          upd.seen_hex_marker = 1'b1;
        end else if (!state_cur.seen_point && (ch == nlc_pkg::CH_POINT)) begin
          upd.seen_point     = 1'b1;
          upd.prev_was_point = 1'b1;
        end else begin
          upd.phase         = nlc_pkg::PH_DONE;
          upd.early_verdict = nlc_pkg::V_NONE;
        end
      end
      nlc_pkg::PH_DONE: begin
        upd.phase = nlc_pkg::PH_DONE;
      end
      default: begin
        upd = state_cur;
      end
    endcase
  end

  // Grade the token from the updated state; clear it at the final character
  always_comb begin
    priority if (upd.phase == nlc_pkg::PH_DONE) begin
      res.verdict = upd.early_verdict;
    end else if (upd.phase != nlc_pkg::PH_BODY) begin
      res.verdict = nlc_pkg::V_NONE;
    end else if (upd.prev_was_point) begin
      res.verdict = nlc_pkg::V_NONE;
    end else if (upd.seen_point) begin
      res.verdict = nlc_pkg::V_FLOAT;
    end else begin
      res.verdict = nlc_pkg::V_INT;
    end
    res.state_next = last ? nlc_pkg::TOK_CLEAR : upd;
  end

endmodule

`default_nettype wire

[src/nlc_out_stage.sv]
// ---------------------------------------------------------------------------
// nlc_out_stage: verdict output register
// Holds one verdict until the receiver takes it; refills in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module nlc_out_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic [1:0] verdict_in,
  output logic            space,
  nlc_out_if.source       dout
);

  logic       out_valid;
  logic [1:0] out_verdict;

  // Room for a new verdict when empty or emptying this cycle
  assign space = !out_valid || dout.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  // Capture the verdict
  always_ff @(posedge clk) begin
    if (load && space) begin
      out_verdict <= verdict_in;
    end
  end

  assign dout.valid   = out_valid;
  assign dout.verdict = out_verdict;

  // A load offered without room would be lost
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> space)
    else $error("nlc_out_stage: verdict loaded while register full");

  // A stalled verdict stays in place
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dout.ready) |=> (out_valid && $stable(out_verdict)))
    else $error("nlc_out_stage: stalled verdict changed");

  // Verdict shows up in the cycle after a load
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && space) |=> out_valid)
    else $error("nlc_out_stage: loaded verdict not presented");

endmodule

`default_nettype wire

[src/numeric_literal_classifier_core.sv]
// ---------------------------------------------------------------------------
// numeric_literal_classifier_core: numeric literal classifier
// Classifies a character stream token by token as integer, float or not a
// number.
//
// Usage:
//   din  : one character per transfer (ch, last); last marks a token's end.
//   dout : one verdict per token (0 none, 1 integer, 2 float, 3 double 'e').
//   cfg  : write of allow_exponent (bit 0); always ready, write only when
//          no token is in flight.
// Throughput: one character per cycle unless a final character waits on a full
//   verdict register, set by the combinational state update between the input
//   register and the verdict register. A final character's verdict passes from
//   the input register through the verdict register onto dout.
// Stall: a held verdict stops only final characters; other characters keep
//   flowing. din.ready drops once a final character waits in the input
//   register behind a full output register.
// Reset: clears the token state and both pipeline registers, and sets
//   allow_exponent to 1.
// ---------------------------------------------------------------------------
`default_nettype none

module numeric_literal_classifier_core (
  input  wire logic  clk,
  input  wire logic  rst,
  nlc_cfg_if.sink    cfg,
  nlc_in_if.sink     din,
  nlc_out_if.source  dout
);

  logic                allow_exponent;
  logic                s1_valid;
  logic [7:0]          s1_ch;
  logic                s1_last;
  logic                s1_adv;
  logic                out_space;
  nlc_pkg::tok_state_t tok;
  nlc_pkg::step_res_t  step;

  // Configuration register, written in any cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_exponent <= nlc_pkg::ALLOW_EXP_RESET;
    end else if (cfg.valid) begin
      allow_exponent <= cfg.data;
    end
  end

  // Advance the input register; final characters need output room
  assign s1_adv    = s1_valid && (!s1_last || out_space);
  assign din.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_ch   <= din.ch;
      s1_last <= din.last;
    end
  end

  // Classify the held character
  nlc_step u_step (
    .ch             (s1_ch),
    .last           (s1_last),
    .allow_exponent (allow_exponent),
    .state_cur      (tok),
    .res            (step)
  );

  // Update the token state on each processed character
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= nlc_pkg::TOK_CLEAR;
    end else if (s1_adv) begin
      tok <= step.state_next;
    end
  end

  // Verdict register
  nlc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_adv && s1_last),
    .verdict_in (step.verdict),
    .space      (out_space),
    .dout       (dout)
  );

  // A token ends with the state back at its start
  a_tok_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (tok == nlc_pkg::TOK_CLEAR))
    else $error("core: token state not cleared after final character");

  // The early verdict is only set once the token is decided
  a_early_idle: assert property (@(posedge clk) disable iff (rst)
    (tok.phase != nlc_pkg::PH_DONE) |-> (tok.early_verdict == nlc_pkg::V_NONE))
    else $error("core: early verdict set in undecided token");

  // Only a final character waiting on a full output register blocks input
  a_block_cause: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> (s1_valid && s1_last && dout.valid && !dout.ready))
    else $error("core: input blocked without a stalled verdict");

  // Hex-marker or point flags imply the token reached its body
  a_flags_body: assert property (@(posedge clk) disable iff (rst)
    (tok.seen_hex_marker || tok.seen_point) |->
      (tok.phase == nlc_pkg::PH_BODY || tok.phase == nlc_pkg::PH_DONE))
    else $error("core: body flags set before the body");

endmodule

`default_nettype wire

[tb/sv/nlc_verdict_checker.sv]
// ---------------------------------------------------------------------------
// nlc_verdict_checker: verdict checker for the numeric literal classifier
// Watches the configuration, character and verdict channels, keeps its own
// token state and exponent mode, and compares every verdict with the oldest
// predicted one. Hands the number of failures and pending verdicts upward.
// ---------------------------------------------------------------------------
module nlc_verdict_checker
  import nlc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  nlc_cfg_if   cfg,
  nlc_in_if    din,
  nlc_out_if   dout,
  output int   fails,
  output int   pending
);

  tok_state_t tok_now;
  tok_state_t tok_next;
  logic       exp_mode;
  logic [1:0] verdicts_due[$];
  logic [1:0] want;

  initial fails = 0;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Advance the token state by one character
  function automatic tok_state_t next_token_state(tok_state_t s, logic allow_e, logic [7:0] c);
    tok_state_t n;
    n = s;
    case (s.phase)
      PH_LEAD: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          n.phase = PH_LEAD;
        end else if (c == CH_MINUS) begin
          n.phase = PH_MINUS;
        end else if (is_digit(c)) begin
          n.phase = PH_BODY;
        end else begin
          n.phase         = PH_DONE;
          n.early_verdict = V_NONE;
        end
      end
      PH_MINUS: begin
        if (is_digit(c)) begin
          n.phase = PH_BODY;
        end else begin
          n.phase         = PH_DONE;
          n.early_verdict = V_NONE;
        end
      end
      PH_BODY: begin
        n.prev_was_point = 1'b0;
        // digits, and a-f once hex is on, leave the state alone
        if (!(is_digit(c) || (s.seen_hex_marker && c >= CH_A && c <= CH_F))) begin
          if (allow_e && c == CH_E) begin
            if (s.seen_exponent) begin
              n.phase         = PH_DONE;
              n.early_verdict = V_ERR;
            end else begin
              n.seen_exponent = 1'b1;
              n.seen_point    = 1'b1;
            end
          end else if (!s.seen_hex_marker && c == CH_X) begin
            n.seen_hex_marker = 1'b1;
          end else if (!s.seen_point && c == CH_POINT) begin
            n.seen_point     = 1'b1;
            n.prev_was_point = 1'b1;
          end else begin
            n.phase         = PH_DONE;
            n.early_verdict = V_NONE;
          end
        end
      end
      default: begin
        n = s;
      end
    endcase
    return n;
  endfunction

  // Verdict of a token whose final character left it in state s
  function automatic logic [1:0] token_verdict(tok_state_t s);
    if (s.phase == PH_DONE) return s.early_verdict;
    if (s.phase != PH_BODY) return V_NONE;
    if (s.prev_was_point) return V_NONE;
    return s.seen_point ? V_FLOAT : V_INT;
  endfunction

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Track configuration and character transfers, check verdict transfers
  always @(posedge clk) begin
    if (rst) begin
      tok_now  <= TOK_CLEAR;
      exp_mode <= ALLOW_EXP_RESET;
      verdicts_due.delete();
      pending  <= 0;
    end else begin
      if (cfg.valid && cfg.ready) exp_mode <= cfg.data;
      if (din.valid && din.ready) begin
        tok_next = next_token_state(tok_now, exp_mode, din.ch);
        if (din.last) begin
          verdicts_due.push_back(token_verdict(tok_next));
          tok_now <= TOK_CLEAR;
        end else begin
          tok_now <= tok_next;
        end
      end
      if (dout.valid && dout.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none expected", dout.verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (dout.verdict !== want)
            report_mismatch($sformatf("verdict %0d, expected %0d", dout.verdict, want));
        end
      end
      pending <= verdicts_due.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb: testbench top for numeric_literal_classifier_core
// Drives directed and random tokens under both exponent modes, with random
// source gaps and sink stalls, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb;
  import nlc_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  bit         calm = 1'b0;
  int         fails;
  int         pending;
  logic [7:0] tok_bytes[$];

  nlc_cfg_if cfg_if ();
  nlc_in_if  din_if ();
  nlc_out_if dout_if ();

  numeric_literal_classifier_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_if),
    .din  (din_if),
    .dout (dout_if)
  );

  nlc_verdict_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .din     (din_if),
    .dout    (dout_if),
    .fails   (fails),
    .pending (pending)
  );

  always #2 clk = ~clk;

  // End the run with a failure if it hangs
  initial begin
    #2000000;
    $display("FAIL numeric_literal_classifier_core");
    $finish;
  end

  // Stall the verdict sink in random bursts, never in the calm tail
  initial begin
    dout_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        dout_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_space();
    return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [7:0] pick_body_char();
    int r;
    r = $urandom_range(0, 15);
    if (r <= 6) return 8'(CH_ZERO + $urandom_range(0, 9));
    if (r == 7) return CH_X;
    if (r <= 9) return 8'(CH_A + $urandom_range(0, 5));
    if (r <= 11) return CH_E;
    if (r == 12) return CH_POINT;
    if (r == 13) return CH_MINUS;
    if (r == 14) return pick_space();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a random token: mostly well-formed, some broken, some noise
  function automatic void make_token();
    int kind;
    kind = $urandom_range(0, 9);
    tok_bytes.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) tok_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) tok_bytes.push_back(pick_space());
    if ($urandom_range(0, 2) == 0) tok_bytes.push_back(CH_MINUS);
    tok_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    repeat ($urandom_range(0, 5)) tok_bytes.push_back(pick_body_char());
    if (kind == 1)
      tok_bytes[$urandom_range(0, tok_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  // Transfer the bytes of tok_bytes, last on the final one
  task automatic send_token();
    bit gappy;
    gappy = !calm && $urandom_range(0, 2) != 0;
    foreach (tok_bytes[i]) begin
      if (gappy && $urandom_range(0, 3) == 0) begin
        din_if.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      din_if.valid <= 1'b1;
      din_if.ch    <= tok_bytes[i];
      din_if.last  <= (i == tok_bytes.size() - 1);
      do @(posedge clk); while (!din_if.ready);
    end
  endtask

  task automatic send_text(input string s);
    tok_bytes.delete();
    for (int i = 0; i < s.len(); i++) tok_bytes.push_back(s[i]);
    send_token();
  endtask

  // Wait for every verdict, then for the pipeline to empty
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_exp_mode(input logic v);
    din_if.valid <= 1'b0;
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int chars_sent;
    rst          <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.ch    <= '0;
    din_if.last  <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens, exponent mode at its reset value
    send_text("\t\015-0");
    send_text("9e");
    send_text("1ee");
    send_text("1e.");
    send_text("0xfe");
    send_text("5.");
    send_text("-");
    send_text(" ");
    send_text("1eeg");
    tok_bytes = '{8'h00};
    send_token();
    tok_bytes = '{8'hFF};
    send_token();

    // Directed tokens with the exponent off
    write_exp_mode(1'b0);
    send_text("2e");
    send_text("3.4");

    // Random phases, alternating exponent mode; the final one runs calm
    for (int p = 0; p < 6; p++) begin
      write_exp_mode(p[0] ? 1'b0 : 1'b1);
      calm = (p == 5);
      chars_sent = 0;
      while (chars_sent < 125) begin
        make_token();
        send_token();
        chars_sent += tok_bytes.size();
      end
    end

    din_if.valid <= 1'b0;
    settle();
    if (fails == 0) begin
      $display("PASS numeric_literal_classifier_core");
    end else begin
      $display("FAIL numeric_literal_classifier_core");
    end
    $finish;
  end

endmodule

[files.f]
src/nlc_pkg.sv
src/nlc_in_if.sv
src/nlc_out_if.sv
src/nlc_cfg_if.sv
src/nlc_step.sv
src/nlc_out_stage.sv
src/numeric_literal_classifier_core.sv
tb/sv/nlc_verdict_checker.sv
tb/sv/tb.sv
